// File: rtl/core/plsu_pkg.sv
// -----------------------------------------------------------------------------
// plsu_pkg
// Shared types and constants for the positional list store unit.
// -----------------------------------------------------------------------------
package plsu_pkg;

   // store geometry
   localparam int CAPACITY   = 64;
   localparam int ELEM_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // transaction field widths
   localparam int TYPE_W   = 3;
   localparam int POS_W    = 7;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // width used for position/count comparisons, with one bit of headroom
   localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   typedef enum logic [TYPE_W-1:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_APPEND = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_READ   = 3'd4,
      OP_NOP5   = 3'd5,
      OP_NOP6   = 3'd6,
      OP_NOP7   = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_SHIFT = 6'b000100,
      S_PUT   = 6'b001000,
      S_READ  = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

endpackage

// File: rtl/core/plsu_req_if.sv
// -----------------------------------------------------------------------------
// plsu_req_if
// Request channel: valid/ready handshake with request type, position, value.
// -----------------------------------------------------------------------------
interface plsu_req_if;

   logic                      valid;
   logic                      ready;
   logic [plsu_pkg::TYPE_W-1:0] req_type;
   logic [plsu_pkg::POS_W-1:0]  position;
   logic [plsu_pkg::VAL_W-1:0]  value_in;

   modport source (output valid, output req_type, output position, output value_in,
                   input ready);
   modport sink   (input valid, input req_type, input position, input value_in,
                   output ready);

endinterface

// File: rtl/core/plsu_rsp_if.sv
// -----------------------------------------------------------------------------
// plsu_rsp_if
// Response channel: valid/ready handshake with status, value read and count.
// -----------------------------------------------------------------------------
interface plsu_rsp_if;

   logic                          valid;
   logic                          ready;
   logic [plsu_pkg::STATUS_W-1:0] status;
   logic [plsu_pkg::VAL_W-1:0]    value_out;
   logic [plsu_pkg::COUNT_W-1:0]  count_out;

   modport source (output valid, output status, output value_out, output count_out,
                   input ready);
   modport sink   (input valid, input status, input value_out, input count_out,
                   output ready);

endinterface

// File: rtl/core/plsu_ram.sv
// -----------------------------------------------------------------------------
// plsu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module plsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/positional_list_store_unit.sv
// -----------------------------------------------------------------------------
// positional_list_store_unit
// Ordered list in a fixed RAM with a count: insert/delete by position, append,
// clear and read-next, each answered by one response transaction.
// -----------------------------------------------------------------------------
// Path to the response register: insert goes through the shift and put states,
//   delete through the shift state, append through the put state and read-next
//   through the RAM read state; clear and unused codes go straight to response.
// Throughput: one request at a time, one entry moved per cycle through the RAM;
//   ready again as the response loads into the output register.
// Reset: synchronous, active high; clears count and handshake state, not RAM.
// -----------------------------------------------------------------------------
module positional_list_store_unit (
   input  logic              clock,
   input  logic              reset,
   plsu_req_if.sink          req_if,
   plsu_rsp_if.source        rsp_if
);

   // ---------------------------------------------------------------------------
   // sequencer state and captured request
   // ---------------------------------------------------------------------------
   plsu_pkg::state_type state_ff, state_in;

   plsu_pkg::op_type                  op_ff;
   logic [plsu_pkg::POS_W-1:0]        pos_ff;
   logic [plsu_pkg::ELEM_WIDTH-1:0]   val_ff;

   logic [plsu_pkg::CNT_W-1:0]        count_ff, count_in;

   // shift engine: read pointer, reads left, direction, write pending from last read
   logic [plsu_pkg::ADDR_W-1:0]       rd_addr_ff, rd_addr_in;
   logic [plsu_pkg::CNT_W-1:0]        rd_left_ff, rd_left_in;
   logic                              up_ff, up_in;
   logic                              pend_ff, pend_in;
   logic [plsu_pkg::ADDR_W-1:0]       pend_addr_ff, pend_addr_in;
   logic [plsu_pkg::ADDR_W-1:0]       put_addr_ff, put_addr_in;

   // result held until the output register is free
   plsu_pkg::status_type              res_status_ff, res_status_in;
   logic [plsu_pkg::ELEM_WIDTH-1:0]   res_value_ff, res_value_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [plsu_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [plsu_pkg::VAL_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [plsu_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // RAM ports
   logic                              ram_wr_en;
   logic [plsu_pkg::ADDR_W-1:0]       ram_wr_addr;
   logic [plsu_pkg::ELEM_WIDTH-1:0]   ram_wr_data;
   logic                              ram_rd_en;
   logic [plsu_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [plsu_pkg::ELEM_WIDTH-1:0]   ram_rd_data;

   // comparison views, one bit wider than either operand
   logic [plsu_pkg::CMP_W-1:0]        pos_x;
   logic [plsu_pkg::CMP_W-1:0]        cnt_x;
   logic                              req_take;

   assign pos_x    = plsu_pkg::CMP_W'(pos_ff);
   assign cnt_x    = plsu_pkg::CMP_W'(count_ff);
   assign req_take = req_if.valid && req_if.ready;

   // ---------------------------------------------------------------------------
   // entry store
   // ---------------------------------------------------------------------------
   plsu_ram #(
      .WIDTH (plsu_pkg::ELEM_WIDTH),
      .DEPTH (plsu_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_addr_in    = rd_addr_ff;
      rd_left_in    = rd_left_ff;
      up_in         = up_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      put_addr_in   = put_addr_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = pend_addr_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_addr_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         plsu_pkg::S_IDLE: begin
            if (req_take) begin
               state_in = plsu_pkg::S_EXEC;
            end
         end

         plsu_pkg::S_EXEC: begin
            res_status_in = plsu_pkg::ST_OK;
            res_value_in  = '0;
            state_in      = plsu_pkg::S_RESP;
            case (op_ff)
               plsu_pkg::OP_INSERT: begin
                  if (pos_x == '0 || pos_x > cnt_x + plsu_pkg::CMP_W'(1)) begin
                     res_status_in = plsu_pkg::ST_RANGE;
                  end else if (cnt_x == plsu_pkg::CMP_W'(plsu_pkg::CAPACITY)) begin
                     res_status_in = plsu_pkg::ST_FULL;
                  end else begin
                     // move entries [pos-1 .. count-1] up by one, top first
                     rd_addr_in  = plsu_pkg::ADDR_W'(count_ff - plsu_pkg::CNT_W'(1));
                     rd_left_in  = plsu_pkg::CNT_W'(cnt_x + plsu_pkg::CMP_W'(1) - pos_x);
                     up_in       = 1'b1;
                     put_addr_in = plsu_pkg::ADDR_W'(pos_ff - plsu_pkg::POS_W'(1));
                     state_in    = plsu_pkg::S_SHIFT;
                  end
               end
               plsu_pkg::OP_DELETE: begin
                  if (pos_x == '0 || pos_x > cnt_x) begin
                     res_status_in = plsu_pkg::ST_RANGE;
                  end else begin
                     // move entries [pos .. count-1] down by one, bottom first
                     rd_addr_in = plsu_pkg::ADDR_W'(pos_ff);
                     rd_left_in = plsu_pkg::CNT_W'(cnt_x - pos_x);
                     up_in      = 1'b0;
                     state_in   = plsu_pkg::S_SHIFT;
                  end
               end
               plsu_pkg::OP_APPEND: begin
                  if (cnt_x == plsu_pkg::CMP_W'(plsu_pkg::CAPACITY)) begin
                     res_status_in = plsu_pkg::ST_FULL;
                  end else begin
                     put_addr_in = plsu_pkg::ADDR_W'(count_ff);
                     state_in    = plsu_pkg::S_PUT;
                  end
               end
               plsu_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
               plsu_pkg::OP_READ: begin
                  if (pos_x == '0 || pos_x + plsu_pkg::CMP_W'(1) > cnt_x ||
                      pos_x >= plsu_pkg::CMP_W'(plsu_pkg::CAPACITY)) begin
                     res_status_in = plsu_pkg::ST_RANGE;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = plsu_pkg::ADDR_W'(pos_ff);
                     state_in    = plsu_pkg::S_READ;
                  end
               end
               default: begin
                  // unused codes: no change, ok status
               end
            endcase
         end

         plsu_pkg::S_SHIFT: begin
            // complete the move whose read was issued last cycle
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end
            if (rd_left_ff != '0) begin
               ram_rd_en    = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = up_ff ? rd_addr_ff + plsu_pkg::ADDR_W'(1)
                                    : rd_addr_ff - plsu_pkg::ADDR_W'(1);
               rd_addr_in   = up_ff ? rd_addr_ff - plsu_pkg::ADDR_W'(1)
                                    : rd_addr_ff + plsu_pkg::ADDR_W'(1);
               rd_left_in   = rd_left_ff - plsu_pkg::CNT_W'(1);
            end else if (!pend_ff) begin
               if (up_ff) begin
                  state_in = plsu_pkg::S_PUT;
               end else begin
                  count_in = count_ff - plsu_pkg::CNT_W'(1);
                  state_in = plsu_pkg::S_RESP;
               end
            end
         end

         plsu_pkg::S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = put_addr_ff;
            ram_wr_data = val_ff;
            count_in    = count_ff + plsu_pkg::CNT_W'(1);
            state_in    = plsu_pkg::S_RESP;
         end

         plsu_pkg::S_READ: begin
            res_value_in = ram_rd_data;
            state_in     = plsu_pkg::S_RESP;
         end

         plsu_pkg::S_RESP: begin
            // hand over once the output register is free or being emptied
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = plsu_pkg::VAL_W'(res_value_ff);
               rsp_count_in  = plsu_pkg::COUNT_W'(count_ff);
               state_in      = plsu_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = plsu_pkg::S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plsu_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------------
   // payload registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= plsu_pkg::op_type'(req_if.req_type);
         pos_ff <= req_if.position;
         val_ff <= plsu_pkg::ELEM_WIDTH'(req_if.value_in);
      end
      rd_addr_ff    <= rd_addr_in;
      rd_left_ff    <= rd_left_in;
      up_ff         <= up_in;
      pend_addr_ff  <= pend_addr_in;
      put_addr_ff   <= put_addr_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ---------------------------------------------------------------------------
   // channel outputs
   // ---------------------------------------------------------------------------
   assign req_if.ready     = (state_ff == plsu_pkg::S_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.value_out = rsp_value_ff;
   assign rsp_if.count_out = rsp_count_ff;

endmodule
